// ===== rtl/core/url_percent_decode_dot_strip_macros.svh =====
// assertion macros shared by the rtl
`ifndef URL_PERCENT_DECODE_DOT_STRIP_MACROS_SVH
`define URL_PERCENT_DECODE_DOT_STRIP_MACROS_SVH

`ifndef SYNTH

// condition holds on every rising clock edge out of reset
`define UPDDS_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// same cycle implication
`define UPDDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next cycle implication
`define UPDDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define UPDDS_ASSERT(lbl, clk, rst_n, cond)
`define UPDDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define UPDDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/updds_pkg.sv =====
package updds_pkg;

    // scan modes
    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_DOT1 = 3'd1;
    localparam logic [2:0] MODE_DOT2 = 3'd2;
    localparam logic [2:0] MODE_ESC1 = 3'd3;
    localparam logic [2:0] MODE_ESC2 = 3'd4;

    // characters
    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    // most beats one input byte can cause
    localparam int MaxOut = 3;

    typedef struct packed {
        logic [2:0] mode;
        logic [3:0] hi_nib;
        logic       hi_nib_valid;
    } scan_state_t;

    // result beats caused by one input byte
    typedef struct packed {
        logic [MaxOut-1:0][7:0] bytes;
        logic [1:0]             cnt;
        logic                   bare;
        logic                   eou;
    } out_group_t;

    // hex digit decode: {valid, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] d;
        logic [4:0] r;
        begin
            r = 5'd0;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                d = c - 8'h30;
                r = {1'b1, d[3:0]};
            end
            else if (c >= 8'h61 && c <= 8'h66)
            begin
                d = c - 8'h57;
                r = {1'b1, d[3:0]};
            end
            else if (c >= 8'h41 && c <= 8'h46)
            begin
                d = c - 8'h37;
                r = {1'b1, d[3:0]};
            end
            return r;
        end
    endfunction

endpackage

// ===== rtl/core/url_percent_decode_dot_strip.sv =====
// channel  | handshake           | payload
// ---------+---------------------+--------------------------------
// in       | in_valid, in_stall  | in_byte, is_last
// out      | out_valid, out_stall| out_byte, has_byte, end_of_url
//
// one input beat is decided per cycle while in_stall is low; its zero to three
// result beats sit in an output group register and leave one per cycle
// a beat that yields one result streams at one beat per cycle while out_stall
// is low, a group of two or three holds in_stall high until its last beat leaves
// rst_n clears the scan state and empties the group register
// out_stall holds the current result beat and backs up into in_stall
`include "url_percent_decode_dot_strip_macros.svh"

module url_percent_decode_dot_strip (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       is_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic       end_of_url
);

    updds_pkg::scan_state_t state_reg;
    updds_pkg::scan_state_t state_next;
    updds_pkg::out_group_t  group;

    logic [updds_pkg::MaxOut-1:0][7:0] bytes_reg;
    logic [1:0]                        cnt_reg;
    logic                              bare_reg;
    logic                              eou_reg;
    logic                              in_take;
    logic                              out_take;

    updds_decode u_decode (
        .state      (state_reg),
        .in_byte    (in_byte),
        .is_last    (is_last),
        .state_next (state_next),
        .group      (group)
    );

    // handshakes
    assign out_valid = (cnt_reg != 2'd0);
    assign out_take  = out_valid && !out_stall;
    assign in_stall  = (cnt_reg != 2'd0) && !(out_take && (cnt_reg == 2'd1));
    assign in_take   = in_valid && !in_stall;

    // result beat at the head of the group
    assign out_byte   = bytes_reg[0];
    assign has_byte   = !bare_reg;
    assign end_of_url = eou_reg && (cnt_reg == 2'd1);

    // scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (in_take)
            state_reg <= state_next;
    end

    // group count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else if (in_take)
            cnt_reg <= group.cnt;
        else if (out_take)
            cnt_reg <= cnt_reg - 2'd1;
    end

    // group payload, shifted toward the head as beats leave
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            bytes_reg <= group.bytes;
            bare_reg  <= group.bare;
            eou_reg   <= group.eou;
        end
        else if (out_take)
        begin
            bytes_reg <= {8'd0, bytes_reg[updds_pkg::MaxOut-1:1]};
        end
    end

    // checks
    `UPDDS_ASSERT_IMP(a_bare_is_end, clk, rst_n, out_valid && !has_byte, end_of_url && (out_byte == 8'd0))
    `UPDDS_ASSERT_IMP(a_burst_stalls_in, clk, rst_n, cnt_reg > 2'd1, in_stall)
    `UPDDS_ASSERT_NEXT(a_last_clears, clk, rst_n, in_valid && !in_stall && is_last, (state_reg.mode == updds_pkg::MODE_IDLE) && !state_reg.hi_nib_valid)

endmodule

// ===== rtl/core/updds_decode.sv =====
module updds_decode (
    input  updds_pkg::scan_state_t state,
    input  logic [7:0]             in_byte,
    input  logic                   is_last,
    output updds_pkg::scan_state_t state_next,
    output updds_pkg::out_group_t  group
);

    logic [updds_pkg::MaxOut-1:0][7:0] slots;
    logic [1:0]                        cnt;
    logic                              fresh;
    logic [4:0]                        hex;
    updds_pkg::scan_state_t            st;

    assign hex = updds_pkg::hex_decode(in_byte);

    // decide one byte against the held state
    always_comb
    begin
        slots = '0;
        cnt   = 2'd0;
        fresh = 1'b0;
        st    = state;

        unique case (state.mode)
            updds_pkg::MODE_DOT1:
            begin
                if (in_byte == updds_pkg::CHAR_SLASH)
                begin
                    st.mode = updds_pkg::MODE_IDLE;
                end
                else if (in_byte == updds_pkg::CHAR_DOT)
                begin
                    st.mode = updds_pkg::MODE_DOT2;
                end
                else
                begin
                    slots[cnt] = updds_pkg::CHAR_DOT;
                    cnt        = cnt + 2'd1;
                    fresh      = 1'b1;
                end
            end
            updds_pkg::MODE_DOT2:
            begin
                if (in_byte == updds_pkg::CHAR_SLASH)
                begin
                    st.mode = updds_pkg::MODE_IDLE;
                end
                else if (in_byte == updds_pkg::CHAR_DOT)
                begin
                    slots[cnt] = updds_pkg::CHAR_DOT;
                    cnt        = cnt + 2'd1;
                end
                else
                begin
                    slots[cnt] = updds_pkg::CHAR_DOT;
                    cnt        = cnt + 2'd1;
                    slots[cnt] = updds_pkg::CHAR_DOT;
                    cnt        = cnt + 2'd1;
                    fresh      = 1'b1;
                end
            end
            updds_pkg::MODE_ESC1:
            begin
                st.hi_nib       = hex[3:0];
                st.hi_nib_valid = hex[4];
                st.mode         = updds_pkg::MODE_ESC2;
            end
            updds_pkg::MODE_ESC2:
            begin
                if (!state.hi_nib_valid)
                    slots[cnt] = 8'd0;
                else if (hex[4])
                    slots[cnt] = {state.hi_nib, hex[3:0]};
                else
                    slots[cnt] = {4'd0, state.hi_nib};
                cnt             = cnt + 2'd1;
                st.hi_nib       = 4'd0;
                st.hi_nib_valid = 1'b0;
                st.mode         = updds_pkg::MODE_IDLE;
            end
            default:
            begin
                fresh = 1'b1;
            end
        endcase

        // byte seen with no dot or escape pending, or after held dots are flushed
        if (fresh)
        begin
            if (in_byte == updds_pkg::CHAR_PCT)
            begin
                st.mode = updds_pkg::MODE_ESC1;
            end
            else if (in_byte == updds_pkg::CHAR_DOT)
            begin
                st.mode = updds_pkg::MODE_DOT1;
            end
            else
            begin
                st.mode    = updds_pkg::MODE_IDLE;
                slots[cnt] = in_byte;
                cnt        = cnt + 2'd1;
            end
        end

        // flush a cut escape at the end and drop held dots
        if (is_last)
        begin
            if (st.mode == updds_pkg::MODE_ESC1)
            begin
                slots[cnt] = 8'd0;
                cnt        = cnt + 2'd1;
            end
            else if (st.mode == updds_pkg::MODE_ESC2)
            begin
                slots[cnt] = st.hi_nib_valid ? {4'd0, st.hi_nib} : 8'd0;
                cnt        = cnt + 2'd1;
            end
            st.mode         = updds_pkg::MODE_IDLE;
            st.hi_nib       = 4'd0;
            st.hi_nib_valid = 1'b0;
        end
    end

    // bare end marker when an end beat carries no byte
    assign state_next  = st;
    assign group.bytes = slots;
    assign group.bare  = is_last && (cnt == 2'd0);
    assign group.cnt   = (is_last && (cnt == 2'd0)) ? 2'd1 : cnt;
    assign group.eou   = is_last;

endmodule
